/* src/sulr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sulr_pkg: shared types and constants of the sensor link receiver
// Beat payload structs, protocol codes and the controller/datapath bundles.
// ---------------------------------------------------------------------------
package sulr_pkg;

  localparam int MsgMax     = 34;
  localparam int NameMax    = 11;
  localparam int AddrW      = 6;
  localparam int IdxW       = 5;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 10;

  localparam logic [CfgIdxW-1:0] CfgKeepalive = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgAckDelay  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgMaxErr    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgReqMode   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgColor     = 3'd4;

  typedef enum logic [2:0] {
    LinkErr  = 3'd0,
    LinkSync = 3'd1,
    LinkInfo = 3'd2,
    LinkAck  = 3'd3,
    LinkData = 3'd4
  } link_e;

  localparam logic [3:0] ErrNone     = 4'd0;
  localparam logic [3:0] ErrSize     = 4'd1;
  localparam logic [3:0] ErrChecksum = 4'd2;
  localparam logic [3:0] ErrAckEarly = 4'd3;
  localparam logic [3:0] ErrMissing  = 4'd4;
  localparam logic [3:0] ErrDup      = 4'd5;
  localparam logic [3:0] ErrModes    = 4'd6;
  localparam logic [3:0] ErrSpeed    = 4'd7;
  localparam logic [3:0] ErrCmd      = 4'd8;
  localparam logic [3:0] ErrName     = 4'd9;
  localparam logic [3:0] ErrNameLen  = 4'd10;
  localparam logic [3:0] ErrWrongMode= 4'd11;
  localparam logic [3:0] ErrFormat   = 4'd12;
  localparam logic [3:0] ErrDataEarly= 4'd13;
  localparam logic [3:0] ErrDataMode = 4'd14;
  localparam logic [3:0] ErrDataLimit= 4'd15;

  localparam logic [3:0] ClsNone    = 4'd0;
  localparam logic [3:0] ClsType    = 4'd1;
  localparam logic [3:0] ClsModes   = 4'd2;
  localparam logic [3:0] ClsSpeed   = 4'd3;
  localparam logic [3:0] ClsVersion = 4'd4;
  localparam logic [3:0] ClsName    = 4'd5;
  localparam logic [3:0] ClsFormat  = 4'd12;
  localparam logic [3:0] ClsData    = 4'd13;
  localparam logic [3:0] ClsCmdUnk  = 4'd14;

  localparam logic [7:0]  ByteAck   = 8'h04;
  localparam logic [7:0]  ByteNack  = 8'h02;
  localparam logic [7:0]  ByteSync  = 8'h40;
  localparam logic [7:0]  ByteIdle  = 8'hFF;
  localparam logic [7:0]  HdrNoCk   = 8'hDC;
  localparam logic [7:0]  TypeMin   = 8'd29;
  localparam logic [7:0]  TypeMax   = 8'd101;
  localparam logic [18:0] BaudSafe  = 19'd2400;
  localparam logic [31:0] BaudMin   = 32'd2400;
  localparam logic [31:0] BaudMax   = 32'd460800;
  localparam logic [11:0] ReqBits   = 12'h813;
  localparam logic [11:0] ModeBits  = 12'hFF0;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  link_status;
    logic [3:0]  error_code;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        baud_valid;
    logic [18:0] baud_rate;
    logic [3:0]  msg_class;
    logic [3:0]  msg_mode;
    logic [7:0]  payload_byte;
    logic [4:0]  payload_index;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic            capture;
    logic            exec;
    logic            rd;
    logic            load;
    logic [IdxW-1:0] idx;
  } ctl_cmd_t;

  typedef struct packed {
    logic            slot_free;
    logic [IdxW-1:0] last_idx;
  } dp_sts_t;

  function automatic logic [7:0] frame_size(input logic [7:0] h);
    logic [7:0] n;
    n = 8'd1;
    if (h[7:6] != 2'b00) begin
      n = (8'd1 << h[5:3]) + 8'd2;
      if (h[7:6] == 2'b10) n = n + 8'd1;
    end
    return n;
  endfunction

endpackage
`default_nettype wire

/* src/sensor_uart_link_receiver_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sensor_uart_link_receiver_top: serial sensor link receiver
// Frames and checks sensor messages and drives the link handshake.
// ---------------------------------------------------------------------------
// Usage:
//  - Input channel (in_*): one beat per received line byte (operation 0)
//    or per 1 ms tick (operation 1).
//  - Output channel (out_*): every input beat yields 1 to 32 result beats;
//    the final one carries last. ACK/NACK to send and baud changes ride on
//    the first beat of a step.
//  - Config channel (cfg_*): always ready; write only while idle.
//  - Flow: the beat is captured, the step executes, then each result beat
//    is read from the single-ported message store, once per result beat,
//    and loaded into the output register. No new input beat is taken
//    during the walk; the next one is taken while the last result beat
//    still waits in the output register.
//  - Reset: link in error state, registers at their defaults, no results.
//  - Output stall: the walk holds on the current beat until out_ready_i.
// ---------------------------------------------------------------------------
module sensor_uart_link_receiver_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire sulr_pkg::in_item_t            in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output sulr_pkg::out_item_t                out_data_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [sulr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [sulr_pkg::CfgDataW-1:0] cfg_data_i
);

  sulr_pkg::ctl_cmd_t cmd;
  sulr_pkg::dp_sts_t  sts;

  // sequencer: handshake and result walk
  sulr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // protocol state, message store and output register
  sulr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

/* src/sulr_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sulr_ctrl: sequencer of the sensor link receiver
// Takes an input beat, runs one step, then walks the result beats.
// ---------------------------------------------------------------------------
module sulr_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire sulr_pkg::dp_sts_t sts_i,
  output sulr_pkg::ctl_cmd_t     cmd_o
);

  typedef enum logic [3:0] {
    CIdle = 4'b0001,
    CExec = 4'b0010,
    CRead = 4'b0100,
    CLoad = 4'b1000
  } ctl_state_e;

  ctl_state_e state_q, state_d;
  logic [sulr_pkg::IdxW-1:0] idx_q, idx_d;
  logic accept;

  assign in_ready_o = (state_q == CIdle);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    cmd_o.capture = accept;
    cmd_o.exec    = 1'b0;
    cmd_o.rd      = 1'b0;
    cmd_o.load    = 1'b0;
    cmd_o.idx     = idx_q;
    case (state_q)
      CIdle: begin
        if (accept) state_d = CExec;
      end
      CExec: begin
        cmd_o.exec = 1'b1;
        idx_d      = '0;
        state_d    = CRead;
      end
      CRead: begin
        cmd_o.rd = 1'b1;
        state_d  = CLoad;
      end
      CLoad: begin
        if (sts_i.slot_free) begin
          cmd_o.load = 1'b1;
          if (idx_q == sts_i.last_idx) begin
            state_d = CIdle;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = CRead;
          end
        end
      end
      default: state_d = CIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CIdle;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> sts_i.slot_free) else $error("load into busy output slot");
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == CExec) else $error("accepted beat not executed");
  a_exec_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == CExec |=> (state_q == CRead && idx_q == '0))
    else $error("result walk did not start at zero");
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == CLoad |-> idx_q <= sts_i.last_idx) else $error("result index overrun");

endmodule
`default_nettype wire

/* src/sulr_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sulr_dp: datapath of the sensor link receiver
// Link state, message store, protocol checks, timers and the output slot.
// ---------------------------------------------------------------------------
module sulr_dp (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire sulr_pkg::in_item_t                in_data_i,
  input  wire sulr_pkg::ctl_cmd_t                cmd_i,
  output sulr_pkg::dp_sts_t                      sts_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [sulr_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire logic [sulr_pkg::CfgDataW-1:0]     cfg_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output sulr_pkg::out_item_t                    out_data_o
);

  // configuration
  logic [9:0] keep_q;
  logic [7:0] ackd_q, maxerr_q, color_q;
  logic [2:0] reqmode_q;

  // protocol state
  sulr_pkg::link_e link_q, link_d;
  logic [5:0]  held_q, held_d;
  logic [11:0] info_q, info_d;
  logic [3:0]  cmode_q, cmode_d;
  logic [4:0]  mcount_q, mcount_d;
  logic [7:0]  dtype_q, dtype_d;
  logic [18:0] pbaud_q, pbaud_d;
  logic [7:0]  derr_q, derr_d;
  logic        dseen_q, dseen_d, trun_q, trun_d;
  logic [9:0]  tcnt_q, tcnt_d;
  logic [7:0]  xor_q, xor_d;
  logic [5:0]  nlen_q, nlen_d;
  logic        zseen_q, zseen_d;
  logic [7:0]  hdr_q [5];

  sulr_pkg::in_item_t item_q;
  logic [7:0] mem_q [sulr_pkg::MsgMax];
  logic [7:0] rd_q;

  // result plan of the current step
  logic [3:0]  ev_err, ev_err_q;
  logic        ev_tx, ev_tx_q, ev_bv, ev_bv_q;
  logic [7:0]  ev_txb, ev_txb_q;
  logic [18:0] ev_baud, ev_baud_q;
  logic [3:0]  p_cls, p_cls_q, p_mode, p_mode_q;
  logic        p_mem, p_mem_q, p_start2, p_start2_q;
  logic [7:0]  p_byte, p_byte_q;
  logic [4:0]  p_last, p_last_q;

  logic        out_valid_q;
  sulr_pkg::out_item_t out_q;

  // step scratch
  logic        we, fail, emit_msg;
  logic [5:0]  wa;
  logic [3:0]  fail_code;
  logic [7:0]  b, h0, fs_new, fs_held, c2, cnt;
  logic [2:0]  cmd;
  logic [3:0]  mode, bitidx;
  logic [31:0] sp;
  logic [8:0]  mplus;
  logic [9:0]  tinc, interval;
  logic        bad;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    link_d = link_q;  held_d = held_q;  info_d = info_q;  cmode_d = cmode_q;
    mcount_d = mcount_q;  dtype_d = dtype_q;  pbaud_d = pbaud_q;  derr_d = derr_q;
    dseen_d = dseen_q;  trun_d = trun_q;  tcnt_d = tcnt_q;  xor_d = xor_q;
    nlen_d = nlen_q;  zseen_d = zseen_q;
    ev_err = sulr_pkg::ErrNone;  ev_tx = 1'b0;  ev_txb = 8'd0;  ev_bv = 1'b0;
    ev_baud = 19'd0;
    p_cls = sulr_pkg::ClsNone;  p_mode = 4'd0;  p_mem = 1'b0;  p_start2 = 1'b0;
    p_byte = 8'd0;  p_last = 5'd0;
    we = 1'b0;  wa = 6'd0;  fail = 1'b0;  fail_code = sulr_pkg::ErrNone;
    emit_msg = 1'b0;
    b = item_q.rx_byte;
    h0 = hdr_q[0];
    fs_new = sulr_pkg::frame_size(b);
    fs_held = sulr_pkg::frame_size(h0);
    cmd = h0[2:0];
    mode = {1'b0, cmd};
    c2 = hdr_q[1];
    if (h0[7:6] == 2'b10 && c2[5]) begin
      mode = mode + 4'd8;
      c2[5] = 1'b0;
    end
    cnt = fs_held - ((h0[7:6] == 2'b10) ? 8'd3 : 8'd2);
    bitidx = 4'(c2[2:0]) + 4'd4;
    sp = {24'd0, hdr_q[1]};
    if (cnt > 8'd1) sp = sp | {16'd0, hdr_q[2], 8'd0};
    if (cnt > 8'd2) sp = sp | {8'd0, hdr_q[3], 16'd0};
    if (cnt > 8'd3) sp = sp | {hdr_q[4], 24'd0};
    mplus = {1'b0, hdr_q[3]} + 9'd1;
    bad = (xor_q != b) && (dtype_q != color_q) && (h0 != sulr_pkg::HdrNoCk);
    tinc = tcnt_q + 10'd1;
    interval = (link_q == sulr_pkg::LinkAck) ? {2'b00, ackd_q} : keep_q;

    if (item_q.operation) begin
      // millisecond tick
      if (trun_q) begin
        if (tinc < interval) begin
          tcnt_d = tinc;
        end else begin
          tcnt_d = 10'd0;
          if (link_q == sulr_pkg::LinkAck) begin
            link_d = sulr_pkg::LinkData;
            ev_bv = 1'b1;
            ev_baud = pbaud_q;
          end else if (derr_q > maxerr_q) begin
            trun_d = 1'b0;
            link_d = sulr_pkg::LinkErr;
            held_d = 6'd0;
            ev_err = sulr_pkg::ErrDataLimit;
            ev_bv = 1'b1;
            ev_baud = sulr_pkg::BaudSafe;
          end else begin
            if (!dseen_q && derr_q != 8'hFF) derr_d = derr_q + 8'd1;
            ev_tx = 1'b1;
            ev_txb = sulr_pkg::ByteNack;
            dseen_d = 1'b0;
          end
        end
      end
    end else if (link_q == sulr_pkg::LinkErr || link_q == sulr_pkg::LinkSync) begin
      // hunting sync on a TYPE message
      link_d = sulr_pkg::LinkSync;
      if (held_q == 6'd0) begin
        if (b == sulr_pkg::ByteSync) begin
          we = 1'b1;  wa = 6'd0;  held_d = 6'd1;
        end
      end else if (held_q == 6'd1) begin
        if (b >= sulr_pkg::TypeMin && b <= sulr_pkg::TypeMax) begin
          we = 1'b1;  wa = 6'd1;  held_d = 6'd2;
        end else begin
          held_d = 6'd0;
        end
      end else begin
        held_d = 6'd0;
        if (b == (8'hFF ^ hdr_q[0] ^ hdr_q[1])) begin
          mcount_d = 5'd1;
          dtype_d = hdr_q[1];
          info_d = 12'd1;
          dseen_d = 1'b0;
          derr_d = 8'd0;
          link_d = sulr_pkg::LinkInfo;
          p_cls = sulr_pkg::ClsType;
          p_byte = hdr_q[1];
        end
      end
    end else if (held_q != 6'd0) begin
      we = 1'b1;
      wa = held_q;
      held_d = held_q + 6'd1;
      xor_d = xor_q ^ b;
      if (held_q >= 6'd2 && !zseen_q) begin
        if (b == 8'd0) zseen_d = 1'b1;
        else nlen_d = nlen_q + 6'd1;
      end
      if ({2'b00, held_q} + 8'd1 >= fs_held) begin
        held_d = 6'd0;
        if (bad) begin
          if (link_q == sulr_pkg::LinkData) begin
            if (derr_q != 8'hFF) derr_d = derr_q + 8'd1;
          end else begin
            fail = 1'b1;  fail_code = sulr_pkg::ErrChecksum;
          end
        end else if (h0[7:6] == 2'b01) begin
          p_mode = 4'd0;
          case (cmd)
            3'd1: begin
              info_d[1] = 1'b1;
              if (info_q[1]) begin
                fail = 1'b1;  fail_code = sulr_pkg::ErrDup;
              end else if (c2 > 8'd7) begin
                fail = 1'b1;  fail_code = sulr_pkg::ErrModes;
              end else begin
                mcount_d = 5'(c2) + 5'd1;
                if (fs_held > 8'd5) mcount_d = (mplus > 9'd31) ? 5'd31 : mplus[4:0];
                p_cls = sulr_pkg::ClsModes;  emit_msg = 1'b1;
              end
            end
            3'd2: begin
              info_d[2] = 1'b1;
              if (info_q[2]) begin
                fail = 1'b1;  fail_code = sulr_pkg::ErrDup;
              end else if (sp < sulr_pkg::BaudMin || sp > sulr_pkg::BaudMax) begin
                fail = 1'b1;  fail_code = sulr_pkg::ErrSpeed;
              end else begin
                pbaud_d = sp[18:0];
                p_cls = sulr_pkg::ClsSpeed;  emit_msg = 1'b1;
              end
            end
            3'd6: begin
              p_cls = sulr_pkg::ClsCmdUnk;  emit_msg = 1'b1;
            end
            3'd7: begin
              info_d[3] = 1'b1;
              if (info_q[3]) begin
                fail = 1'b1;  fail_code = sulr_pkg::ErrDup;
              end else begin
                p_cls = sulr_pkg::ClsVersion;  emit_msg = 1'b1;
              end
            end
            default: begin
              fail = 1'b1;  fail_code = sulr_pkg::ErrCmd;
            end
          endcase
        end else if (h0[7:6] == 2'b10) begin
          p_mode = mode;
          p_start2 = 1'b1;
          if (c2 == 8'd0) begin
            info_d = info_q & ~sulr_pkg::ModeBits;
            if (hdr_q[2] < 8'h41 || hdr_q[2] > 8'h7A) begin
              fail = 1'b1;  fail_code = sulr_pkg::ErrName;
            end else if (nlen_q > 6'(sulr_pkg::NameMax)) begin
              fail = 1'b1;  fail_code = sulr_pkg::ErrNameLen;
            end else begin
              cmode_d = mode;
              info_d[4] = 1'b1;
              p_cls = sulr_pkg::ClsName;  emit_msg = 1'b1;
            end
          end else if (c2 >= 8'd1 && c2 <= 8'd6) begin
            if (cmode_q != mode) begin
              fail = 1'b1;  fail_code = sulr_pkg::ErrWrongMode;
            end else begin
              info_d[bitidx] = 1'b1;
              if (info_q[bitidx]) begin
                fail = 1'b1;  fail_code = sulr_pkg::ErrDup;
              end else begin
                p_cls = sulr_pkg::ClsName + c2[3:0];  emit_msg = 1'b1;
              end
            end
          end else if (c2 == 8'h80) begin
            if (cmode_q != mode) begin
              fail = 1'b1;  fail_code = sulr_pkg::ErrWrongMode;
            end else if (info_q[11]) begin
              fail = 1'b1;  fail_code = sulr_pkg::ErrDup;
            end else begin
              info_d[11] = 1'b1;
              if (hdr_q[2] == 8'd0 || fs_held < 8'd7) begin
                fail = 1'b1;  fail_code = sulr_pkg::ErrFormat;
              end else if (((info_q | 12'h800) & sulr_pkg::ReqBits) != sulr_pkg::ReqBits) begin
                fail = 1'b1;  fail_code = sulr_pkg::ErrMissing;
              end else if (hdr_q[3] > 8'd3) begin
                fail = 1'b1;  fail_code = sulr_pkg::ErrFormat;
              end else begin
                if (cmode_q != 4'd0) cmode_d = cmode_q - 4'd1;
                p_cls = sulr_pkg::ClsFormat;  emit_msg = 1'b1;
              end
            end
          end
        end else begin
          // data message
          p_mode = mode;
          if (link_q != sulr_pkg::LinkData) begin
            fail = 1'b1;  fail_code = sulr_pkg::ErrDataEarly;
          end else if (mode != cmode_q && mode != {1'b0, reqmode_q}) begin
            fail = 1'b1;  fail_code = sulr_pkg::ErrDataMode;
          end else begin
            cmode_d = mode;
            dseen_d = 1'b1;
            if (derr_q != 8'd0) derr_d = derr_q - 8'd1;
            p_cls = sulr_pkg::ClsData;  emit_msg = 1'b1;
          end
        end
      end
    end else if (b == sulr_pkg::ByteIdle) begin
      // filler between messages
    end else if (fs_new > 8'(sulr_pkg::MsgMax)) begin
      fail = 1'b1;  fail_code = sulr_pkg::ErrSize;
    end else begin
      we = 1'b1;  wa = 6'd0;  held_d = 6'd1;
      xor_d = 8'hFF ^ b;
      nlen_d = 6'd0;
      zseen_d = 1'b0;
      if (fs_new == 8'd1) begin
        held_d = 6'd0;
        if (b[2:0] == 3'd4) begin
          if (mcount_q == 5'd0) begin
            fail = 1'b1;  fail_code = sulr_pkg::ErrAckEarly;
          end else if ((info_q & sulr_pkg::ReqBits) != sulr_pkg::ReqBits) begin
            fail = 1'b1;  fail_code = sulr_pkg::ErrMissing;
          end else begin
            link_d = sulr_pkg::LinkAck;
            ev_tx = 1'b1;
            ev_txb = sulr_pkg::ByteAck;
            trun_d = 1'b1;
            tcnt_d = 10'd0;
          end
        end
      end
    end

    if (emit_msg) begin
      p_mem = 1'b1;
      p_last = 5'(cnt - 8'd1);
    end else if (!(p_cls == sulr_pkg::ClsType)) begin
      p_cls = sulr_pkg::ClsNone;
      p_mode = 4'd0;
      p_start2 = 1'b0;
    end else begin
      p_mode = 4'd0;
    end

    if (fail) begin
      link_d = sulr_pkg::LinkErr;
      held_d = 6'd0;
      pbaud_d = sulr_pkg::BaudSafe;
      trun_d = 1'b0;
      tcnt_d = 10'd0;
      ev_err = fail_code;
      ev_bv = 1'b1;
      ev_baud = sulr_pkg::BaudSafe;
      p_cls = sulr_pkg::ClsNone;
      p_mode = 4'd0;
      p_mem = 1'b0;
      p_byte = 8'd0;
      p_last = 5'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q <= 10'd100;  ackd_q <= 8'd10;  maxerr_q <= 8'd6;
      reqmode_q <= 3'd0;  color_q <= 8'd29;
      link_q <= sulr_pkg::LinkErr;  held_q <= 6'd0;  info_q <= 12'd0;
      cmode_q <= 4'd0;  mcount_q <= 5'd0;  dtype_q <= 8'd0;  pbaud_q <= 19'd0;
      derr_q <= 8'd0;  dseen_q <= 1'b0;  trun_q <= 1'b0;  tcnt_q <= 10'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          sulr_pkg::CfgKeepalive: keep_q    <= cfg_data_i;
          sulr_pkg::CfgAckDelay:  ackd_q    <= cfg_data_i[7:0];
          sulr_pkg::CfgMaxErr:    maxerr_q  <= cfg_data_i[7:0];
          sulr_pkg::CfgReqMode:   reqmode_q <= cfg_data_i[2:0];
          sulr_pkg::CfgColor:     color_q   <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (cmd_i.exec) begin
        link_q <= link_d;  held_q <= held_d;  info_q <= info_d;  cmode_q <= cmode_d;
        mcount_q <= mcount_d;  dtype_q <= dtype_d;  pbaud_q <= pbaud_d;
        derr_q <= derr_d;  dseen_q <= dseen_d;  trun_q <= trun_d;  tcnt_q <= tcnt_d;
      end
      if (cmd_i.load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) item_q <= in_data_i;
    if (cmd_i.exec) begin
      xor_q <= xor_d;  nlen_q <= nlen_d;  zseen_q <= zseen_d;
      ev_err_q <= ev_err;  ev_tx_q <= ev_tx;  ev_txb_q <= ev_txb;
      ev_bv_q <= ev_bv;  ev_baud_q <= ev_baud;
      p_cls_q <= p_cls;  p_mode_q <= p_mode;  p_mem_q <= p_mem;
      p_start2_q <= p_start2;  p_byte_q <= p_byte;  p_last_q <= p_last;
      if (we) begin
        mem_q[wa] <= b;
        if (wa < 6'd5) hdr_q[wa[2:0]] <= b;
      end
    end
    if (cmd_i.rd) rd_q <= mem_q[6'(cmd_i.idx) + (p_start2_q ? 6'd2 : 6'd1)];
    if (cmd_i.load) begin
      out_q.link_status   <= link_q;
      out_q.error_code    <= (cmd_i.idx == '0) ? ev_err_q : 4'd0;
      out_q.tx_valid      <= (cmd_i.idx == '0) && ev_tx_q;
      out_q.tx_byte       <= (cmd_i.idx == '0) ? ev_txb_q : 8'd0;
      out_q.baud_valid    <= (cmd_i.idx == '0) && ev_bv_q;
      out_q.baud_rate     <= (cmd_i.idx == '0) ? ev_baud_q : 19'd0;
      out_q.msg_class     <= p_cls_q;
      out_q.msg_mode      <= p_mode_q;
      out_q.payload_byte  <= p_mem_q ? rd_q : p_byte_q;
      out_q.payload_index <= p_mem_q ? cmd_i.idx : 5'd0;
      out_q.last          <= (cmd_i.idx == p_last_q);
    end
  end

  assign sts_o.slot_free = !out_valid_q || out_ready_i;
  assign sts_o.last_idx  = p_last_q;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;

endmodule
`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: testbench of the serial sensor link receiver
// Drives byte and tick beats through sync, info, ack and data phases,
// predicts every result beat in a behavioral model and checks each field.
// ---------------------------------------------------------------------------
module tb_top;
  import sulr_pkg::*;

  // link and protocol predictor with its own copy of state and registers
  class link_scoreboard;
    int unsigned ka_ms, ackd_ms, max_err, req_mode, color_type;
    int unsigned lstate, held, seen, cur_mode, n_modes, dev_type, pend_baud;
    int unsigned err_cnt, got_data, tmr_on, tmr_cnt;
    byte unsigned store[MsgMax];
    out_item_t beats_due[$];
    out_item_t step_q[$];
    int unsigned ev_err, ev_tx, ev_txb, ev_bv, ev_baud;
    int mismatches, beats_checked, items_noted, tx_seen, baud_seen, pay_seen;

    function new();
      ka_ms = 100; ackd_ms = 10; max_err = 6; req_mode = 0; color_type = 29;
      lstate = LinkErr; held = 0; seen = 0; cur_mode = 0; n_modes = 0;
      dev_type = 0; pend_baud = 0; err_cnt = 0; got_data = 0;
      tmr_on = 0; tmr_cnt = 0;
      mismatches = 0; beats_checked = 0; items_noted = 0;
      tx_seen = 0; baud_seen = 0; pay_seen = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, int unsigned v);
      case (idx)
        CfgKeepalive: ka_ms = v & 10'h3FF;
        CfgAckDelay:  ackd_ms = v & 8'hFF;
        CfgMaxErr:    max_err = v & 8'hFF;
        CfgReqMode:   req_mode = v & 3'h7;
        CfgColor:     color_type = v & 8'hFF;
        default: ;
      endcase
    endfunction

    function void push_beat(int unsigned cls, int unsigned md, int unsigned b,
                            int unsigned i);
      out_item_t r;
      if (step_q.size() >= 32) return;
      r = '0;
      r.msg_class = cls; r.msg_mode = md; r.payload_byte = b; r.payload_index = i;
      step_q.push_back(r);
    endfunction

    function void drop_link(int unsigned code);
      lstate = LinkErr; held = 0; pend_baud = 2400; tmr_on = 0; tmr_cnt = 0;
      ev_err = code; ev_bv = 1; ev_baud = 2400;
    endfunction

    function int unsigned msg_len(int unsigned h);
      int unsigned n;
      if ((h & 8'hC0) == 0) return 1;
      n = (1 << ((h >> 3) & 7)) + 2;
      if ((h & 8'hC0) == 8'h80) n++;
      return n;
    endfunction

    function bit set_seen(int unsigned b);
      bit was;
      was = seen[b];
      seen = (seen | (1 << b)) & 12'hFFF;
      return was;
    endfunction

    function void bump_err();
      if (err_cnt < 255) err_cnt++;
    endfunction

    function void hunt_sync(int unsigned b);
      if (held == 0) begin
        if (b == ByteSync) begin store[0] = b; held = 1; end
        return;
      end
      if (held == 1) begin
        if (b >= TypeMin && b <= TypeMax) begin store[1] = b; held = 2; end
        else held = 0;
        return;
      end
      if (b != (8'hFF ^ store[0] ^ store[1])) begin held = 0; return; end
      n_modes = 1; dev_type = store[1]; held = 0; seen = 1; got_data = 0;
      err_cnt = 0; lstate = LinkInfo;
      push_beat(ClsType, 0, dev_type, 0);
    endfunction

    function void take_msg(int unsigned sz);
      int unsigned h, kind, cmd, md, c2, first, cnt, cls, omd, ck, sp, nlen, m;
      h = store[0]; kind = h & 8'hC0; cmd = h & 7; md = cmd;
      cls = ClsNone; omd = 0;
      if (sz < 2) begin
        if (cmd == 4) begin
          if (n_modes == 0) begin drop_link(ErrAckEarly); return; end
          if ((seen & ReqBits) != ReqBits) begin drop_link(ErrMissing); return; end
          lstate = LinkAck; ev_tx = 1; ev_txb = ByteAck; tmr_on = 1; tmr_cnt = 0;
        end
        return;
      end
      c2 = store[1];
      if (kind == 8'h80 && (c2 & 8'h20)) begin md += 8; c2 &= ~32'h20; end
      ck = 8'hFF;
      for (int i = 0; i + 1 < sz; i++) ck ^= store[i];
      if (ck != store[sz-1] && dev_type != color_type && h != HdrNoCk) begin
        if (lstate == LinkData) begin bump_err(); return; end
        drop_link(ErrChecksum);
        return;
      end
      first = (kind == 8'h80) ? 2 : 1;
      cnt = sz - first - 1;
      if (kind == 8'h40) begin
        if (cmd == 1) begin
          if (set_seen(1)) begin drop_link(ErrDup); return; end
          if (c2 > 7) begin drop_link(ErrModes); return; end
          n_modes = c2 + 1;
          if (sz > 5) begin m = store[3] + 1; n_modes = m > 31 ? 31 : m; end
          cls = ClsModes;
        end else if (cmd == 2) begin
          if (set_seen(2)) begin drop_link(ErrDup); return; end
          sp = 0;
          for (int i = 0; i < 4 && i < cnt; i++) sp |= store[1+i] << (8*i);
          if (sp < BaudMin || sp > BaudMax) begin drop_link(ErrSpeed); return; end
          pend_baud = sp; cls = ClsSpeed;
        end else if (cmd == 6) cls = ClsCmdUnk;
        else if (cmd == 7) begin
          if (set_seen(3)) begin drop_link(ErrDup); return; end
          cls = ClsVersion;
        end else begin drop_link(ErrCmd); return; end
      end else if (kind == 8'h80) begin
        omd = md;
        if (c2 == 0) begin
          nlen = 0;
          seen &= ~ModeBits;
          if (store[2] < "A" || store[2] > "z") begin drop_link(ErrName); return; end
          while (nlen < cnt && store[2+nlen] != 0) nlen++;
          if (nlen > NameMax) begin drop_link(ErrNameLen); return; end
          cur_mode = md & 15; seen |= 1 << 4; cls = ClsName;
        end else if (c2 >= 1 && c2 <= 6) begin
          if (cur_mode != md) begin drop_link(ErrWrongMode); return; end
          if (set_seen(4 + c2)) begin drop_link(ErrDup); return; end
          cls = 5 + c2;
        end else if (c2 == 8'h80) begin
          if (cur_mode != md) begin drop_link(ErrWrongMode); return; end
          if (set_seen(11)) begin drop_link(ErrDup); return; end
          if (store[2] == 0 || sz < 7) begin drop_link(ErrFormat); return; end
          if ((seen & ReqBits) != ReqBits) begin drop_link(ErrMissing); return; end
          if (store[3] > 3) begin drop_link(ErrFormat); return; end
          if (cur_mode > 0) cur_mode--;
          cls = ClsFormat;
        end else return;
      end else begin
        if (lstate != LinkData) begin drop_link(ErrDataEarly); return; end
        if (md > 7) begin drop_link(ErrDataMode); return; end
        if (md != cur_mode) begin
          if (md == req_mode) cur_mode = md;
          else begin drop_link(ErrDataMode); return; end
        end
        got_data = 1;
        if (err_cnt > 0) err_cnt--;
        cls = ClsData; omd = md;
      end
      for (int i = 0; i < cnt && i < 32; i++) push_beat(cls, omd, store[first+i], i);
    endfunction

    function void take_byte(int unsigned b);
      int unsigned sz;
      if (lstate == LinkErr) lstate = LinkSync;
      if (lstate == LinkSync) begin hunt_sync(b); return; end
      if (held != 0) begin
        sz = msg_len(store[0]);
        if (held >= MsgMax || sz > MsgMax) begin held = 0; return; end
        store[held++] = b;
        if (held < sz) return;
      end else if (b == ByteIdle) return;
      else begin
        sz = msg_len(b);
        if (sz > MsgMax) begin drop_link(ErrSize); return; end
        store[0] = b; held = 1;
        if (sz > 1) return;
      end
      held = 0;
      take_msg(sz);
    endfunction

    function void take_tick();
      int unsigned lim;
      if (!tmr_on) return;
      tmr_cnt = (tmr_cnt + 1) & 10'h3FF;
      lim = (lstate == LinkAck) ? ackd_ms : ka_ms;
      if (tmr_cnt < lim) return;
      tmr_cnt = 0;
      if (lstate == LinkAck) begin
        lstate = LinkData; ev_bv = 1; ev_baud = pend_baud;
      end else if (err_cnt > max_err) begin
        tmr_on = 0; lstate = LinkErr; held = 0;
        ev_err = ErrDataLimit; ev_bv = 1; ev_baud = 2400;
      end else begin
        if (!got_data) bump_err();
        ev_tx = 1; ev_txb = ByteNack; got_data = 0;
      end
    endfunction

    // note one accepted input beat and queue the result beats it causes
    function void note_input(in_item_t it);
      out_item_t r;
      step_q.delete();
      ev_err = 0; ev_tx = 0; ev_txb = 0; ev_bv = 0; ev_baud = 0;
      if (it.operation) take_tick();
      else take_byte(it.rx_byte);
      if (step_q.size() == 0) push_beat(ClsNone, 0, 0, 0);
      foreach (step_q[k]) begin
        r = step_q[k];
        r.link_status = lstate;
        if (k == 0) begin
          r.error_code = ev_err; r.tx_valid = ev_tx; r.tx_byte = ev_txb;
          r.baud_valid = ev_bv; r.baud_rate = ev_baud;
        end
        r.last = (k == step_q.size() - 1);
        beats_due.push_back(r);
      end
      items_noted++;
    endfunction

    // compare one accepted result beat with the oldest expectation
    function void check_result(out_item_t got);
      out_item_t exp_b;
      beats_checked++;
      if (beats_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result beat %p", got);
        return;
      end
      exp_b = beats_due.pop_front();
      if (got !== exp_b) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: beat %0d mismatch\n  expected %p\n  actual   %p",
                   beats_checked, exp_b, got);
      end
      if (got.tx_valid) tx_seen++;
      if (got.baud_valid) baud_seen++;
      if (got.msg_class != ClsNone) pay_seen++;
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  in_item_t in_data;
  out_item_t out_data;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  link_scoreboard sb;
  int send_idle_pct, recv_stall_pct;
  int hold_off_cycles;

  sensor_uart_link_receiver_top dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // receiver: stall at random, or hold off for a counted stretch
  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready <= 1'b0;
    end else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // every beat accepted at a rising edge goes to the checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // send one input beat; the predictor sees it at its acceptance edge.
  // valid drops after each beat, while the block is still busy
  task automatic send_item(logic op, logic [7:0] b);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(negedge clk);
    in_valid <= 1'b1;
    in_data <= '{operation: op, rx_byte: b};
    do @(posedge clk); while (!in_ready);
    sb.note_input('{operation: op, rx_byte: b});
    @(negedge clk);
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item(1'b0, b);
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_item(1'b1, $urandom_range(255));
  endtask

  // message with header, body and a trailing checksum (optionally broken)
  task automatic send_msg(logic [7:0] hdr, byte unsigned body[$], bit bad_ck = 0);
    logic [7:0] ck;
    ck = 8'hFF ^ hdr;
    send_byte(hdr);
    foreach (body[i]) begin
      send_byte(body[i]);
      ck ^= body[i];
    end
    send_byte(bad_ck ? ~ck : ck);
  endtask

  // wait until every expected result has arrived, plus the pipe drain
  task automatic drain();
    while (sb.beats_due.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, int unsigned v);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_sync(logic [7:0] dtype);
    send_byte(ByteSync); send_byte(dtype); send_byte(8'hFF ^ ByteSync ^ dtype);
  endtask

  // short handshake: sync, modes, speed, name and format per mode, ACK,
  // then the baud switch after the ack delay
  task automatic bring_up(logic [7:0] dtype, int nm);
    byte unsigned b[$];
    int unsigned sp;
    send_sync(dtype);
    b = '{nm - 1, 0}; send_msg(8'h49, b);
    sp = $urandom_range(1) ? 115200 : $urandom_range(460800, 2400);
    b = '{sp[7:0], sp[15:8], sp[23:16], sp[31:24]};
    send_msg(8'h52, b);
    for (int m = nm - 1; m >= 0; m--) begin
      b = '{0, "A" + m, "x", 0, 0};
      send_msg(8'h90 | m[2:0], b);
      b = '{8'h80, 1, $urandom_range(3), 3, 0};
      send_msg(8'h90 | m[2:0], b);
    end
    send_byte(8'h04);
    send_ticks(sb.ackd_ms);
  endtask

  task automatic send_data(int md, int sz_code, bit bad);
    byte unsigned b[$];
    for (int i = 0; i < (1 << sz_code); i++) b.push_back($urandom);
    send_msg(8'hC0 | (sz_code << 3) | md, b, bad);
  endtask

  // random traffic: short data in the current mode, ticks and filler, re-syncing when the link leaves the data phase
  task automatic random_traffic(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 60) send_data(sb.cur_mode & 7, $urandom_range(1), $urandom_range(7) == 0);
      else if (k < 85) send_ticks($urandom_range(2, 1));
      else send_byte(ByteIdle);
      if (sb.lstate != LinkData) begin
        drain();
        bring_up($urandom_range(101, 29), 1);
      end
    end
  endtask

  initial begin
    byte unsigned b[$];
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0; cfg_valid = 1'b0;
    cfg_index = '0; cfg_data = '0; send_idle_pct = 0; recv_stall_pct = 0;
    hold_off_cycles = 0; out_ready = 1'b0;
    sb = new();
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: short intervals, zero error limit, bad sync and protocol errors
    write_cfg(CfgKeepalive, 3); write_cfg(CfgAckDelay, 1);
    write_cfg(CfgMaxErr, 0); write_cfg(CfgReqMode, 4); write_cfg(CfgColor, 255);
    send_ticks(1);
    send_byte(ByteSync); send_byte(8'd28); send_byte(8'h00);
    send_byte(8'h04);
    send_sync(8'd101);
    send_byte(8'h04);
    send_sync(8'd29);
    b = '{8'h09, 8'h00}; send_msg(8'h49, b);
    send_byte(8'hFF);
    send_sync(8'd29);
    send_byte(8'hF8);
    send_sync(8'd29);
    b = '{8'h05, 8'h00}; send_msg(8'h49, b, 1);
    send_sync(8'd40);
    b = '{8'h00, 8'h00, 8'h00, 8'h00}; send_msg(8'h52, b);
    drain();

    // bring-up in one mode, data in the current and then the requested mode
    bring_up(8'd29, 1);
    send_data(0, 0, 0); send_data(0, 1, 0); send_data(0, 1, 1);
    b = '{8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h77, 8'h88};
    send_msg(HdrNoCk, b, 1);
    drain();
    write_cfg(CfgMaxErr, 255);

    // random phases with the idling mixes
    random_traffic(3);
    send_idle_pct = 47; random_traffic(3);
    send_idle_pct = 0; recv_stall_pct = 47; random_traffic(3);
    send_idle_pct = 14; recv_stall_pct = 14;
    hold_off_cycles = 400;
    random_traffic(3);
    drain();
    random_traffic(3);
    send_idle_pct = 0; recv_stall_pct = 0;
    drain();

    // keepalive errors until the link drops
    write_cfg(CfgMaxErr, 0);
    send_ticks(10);
    drain();

    $display("Covered %0d input beats and %0d result beats: %0d with tx, %0d baud",
             sb.items_noted, sb.beats_checked, sb.tx_seen, sb.baud_seen);
    $display("changes, %0d payload beats; %0d mismatches.", sb.pay_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.beats_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
